[rtl/tls_pkg.sv]
package tls_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SHAPER_SCALE_Q15 = 20861;

    localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_W      = 17;
    localparam int LFO_W       = 17;

    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int ANG_TAB_W    = 31;
    localparam int ANG_W        = 33;
    localparam int CORD_W       = SAMPLE_BITS + 18;
    localparam int RES_W        = SAMPLE_BITS + 2;
    localparam int RAD_W        = SAMPLE_BITS + 3;
    localparam int MUL_W        = 34;
    localparam int PROD_W       = 64;

    localparam longint CORDIC_GAIN_Q30 = 652032874;
    localparam longint QUARTER_TURN    = 64'sd1073741824;
    localparam longint HALF_TURN       = 64'sd2147483648;
    localparam longint SINE_STEP       = 64'sd4294967296 / SINE_TABLE_DEPTH;

    localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
    localparam logic [31:0] SQ_T48     = 32'd2061584302;
    localparam logic [31:0] SQ_T50     = 32'd2147483648;
    localparam logic [31:0] SQ_T98     = 32'd4209067950;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPER_ENABLE   = 3'd0,
        REG_SHAPER_GAIN     = 3'd1,
        REG_WAVE_SELECT     = 3'd2,
        REG_RATE_MULTIPLIER = 3'd3,
        REG_DEPTH_ONE       = 3'd4,
        REG_RATE_ONE_STEP   = 3'd5,
        REG_MOD_DEPTH_STEP  = 3'd6,
        REG_RATE_TWO_STEP   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_TRI    = 2'd1,
        WAVE_SQUARE = 2'd2,
        WAVE_RING   = 2'd3
    } t_wave;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SIN1,
        OP_LFO1,
        OP_GMUL,
        OP_GAIN,
        OP_INC,
        OP_PHASE,
        OP_CH,
        OP_SHV,
        OP_CORD,
        OP_RAD,
        OP_RADR,
        OP_SCL,
        OP_SCLR,
        OP_OUTM,
        OP_OUTR,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [STEP_W-1:0] step;
        logic              ch;
        logic              neg;
    } t_cmd;

    typedef struct packed {
        logic shaper_on;
        logic v_neg;
    } t_status;

    typedef logic [ANG_TAB_W-1:0] t_ang_tab [CORDIC_STEPS];

    localparam t_ang_tab CORDIC_ANGLE = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
        31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
        31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722,
        31'd20861, 31'd10430, 31'd5215, 31'd2608, 31'd1304,
        31'd652, 31'd326, 31'd163, 31'd81, 31'd41,
        31'd20, 31'd10, 31'd5, 31'd3, 31'd1
    };

    typedef logic signed [SINE_W-1:0] t_sine_tab [SINE_TABLE_DEPTH];

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        longint    a;
        longint    x;
        longint    y;
        longint    z;
        longint    dx;
        longint    dy;
        longint    s;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            a = longint'(k) * SINE_STEP;
            if (a >= HALF_TURN) a = a - 2 * HALF_TURN;
            if (a > QUARTER_TURN) a = HALF_TURN - a;
            if (a < -QUARTER_TURN) a = -HALF_TURN - a;
            x = CORDIC_GAIN_Q30;
            y = 0;
            z = a;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(CORDIC_ANGLE[i]);
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(CORDIC_ANGLE[i]);
                end
            end
            s = (y + 64'sd16384) >>> 15;
            if (s > 32768) s = 32768;
            if (s < -32768) s = -32768;
            tab[k] = s[SINE_W-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage

[rtl/tls_in_if.sv]
interface tls_in_if
    import tls_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

[rtl/tls_out_if.sv]
interface tls_out_if
    import tls_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

[rtl/tls_ctrl.sv]
module tls_ctrl
    import tls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_SIN1, S_LFO1, S_GMUL, S_GAIN, S_INC, S_PHASE, S_CH, S_SHV,
        S_CORD, S_RAD, S_RADR, S_SCL, S_SCLR, S_OUTM, S_OUTR, S_EMIT
    } t_state;

    t_state            r_state;
    logic              r_out_valid;
    logic              r_ch;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;
    logic              emit_ok;

    assign emit_ok     = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.step = r_step;
        o_cmd.ch   = r_ch;
        o_cmd.neg  = r_neg;
        case (r_state)
            S_IDLE:  if (i_in_valid) o_cmd.op = OP_LOAD;
            S_SIN1:  o_cmd.op = OP_SIN1;
            S_LFO1:  o_cmd.op = OP_LFO1;
            S_GMUL:  o_cmd.op = OP_GMUL;
            S_GAIN:  o_cmd.op = OP_GAIN;
            S_INC:   o_cmd.op = OP_INC;
            S_PHASE: o_cmd.op = OP_PHASE;
            S_CH:    o_cmd.op = OP_CH;
            S_SHV:   o_cmd.op = OP_SHV;
            S_CORD:  o_cmd.op = OP_CORD;
            S_RAD:   o_cmd.op = OP_RAD;
            S_RADR:  o_cmd.op = OP_RADR;
            S_SCL:   o_cmd.op = OP_SCL;
            S_SCLR:  o_cmd.op = OP_SCLR;
            S_OUTM:  o_cmd.op = OP_OUTM;
            S_OUTR:  o_cmd.op = OP_OUTR;
            S_EMIT:  if (emit_ok) o_cmd.op = OP_EMIT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ch        <= 1'b0;
            r_neg       <= 1'b0;
            r_step      <= '0;
        end else begin
            if (r_state == S_EMIT && emit_ok) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_SIN1;
                end
                S_SIN1:  r_state <= S_LFO1;
                S_LFO1:  r_state <= S_GMUL;
                S_GMUL:  r_state <= S_GAIN;
                S_GAIN:  r_state <= S_INC;
                S_INC:   r_state <= S_PHASE;
                S_PHASE: begin
                    r_ch    <= 1'b0;
                    r_state <= S_CH;
                end
                S_CH: begin
                    r_state <= i_status.shaper_on ? S_SHV : S_OUTM;
                end
                S_SHV: begin
                    r_neg   <= i_status.v_neg;
                    r_step  <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_RAD;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_RAD:  r_state <= S_RADR;
                S_RADR: r_state <= S_SCL;
                S_SCL:  r_state <= S_SCLR;
                S_SCLR: begin
                    if (r_neg) begin
                        r_neg   <= 1'b0;
                        r_step  <= '0;
                        r_state <= S_CORD;
                    end else begin
                        r_state <= S_OUTM;
                    end
                end
                S_OUTM: r_state <= S_OUTR;
                S_OUTR: begin
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_state <= S_CH;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/tls_dp.sv]
module tls_dp
    import tls_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  t_cmd                          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    output t_status                       o_status,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out
);

    localparam int RAD_SHIFT = 61 - SAMPLE_BITS;
    localparam logic signed [PROD_W-1:0] ONE_V   = 64'sd1 <<< (SAMPLE_BITS + 10);
    localparam logic signed [PROD_W-1:0] RAD_RND = 64'sd1 <<< (RAD_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] SCL_RND = 64'sd1 <<< 14;
    localparam logic signed [PROD_W-1:0] OUT_RND = 64'sd1 <<< 29;
    localparam logic signed [PROD_W-1:0] SAT_HI  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [PROD_W-1:0] SAT_LO  = -(64'sd1 <<< (SAMPLE_BITS - 1));

    logic        r_shaper_enable;
    logic [15:0] r_shaper_gain;
    t_wave       r_wave_select;
    logic [2:0]  r_rate_multiplier;
    logic [15:0] r_depth_one;
    logic [23:0] r_rate_one_step;
    logic [21:0] r_mod_depth_step;
    logic [16:0] r_rate_two_step;

    logic [31:0] r_ph1;
    logic [31:0] r_ph2;

    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic signed [SINE_W-1:0]      r_sin;
    logic signed [LFO_W-1:0]       r_lfo1;
    logic [LFO_W-1:0]              r_lfo2;
    logic signed [31:0]            r_gain;
    logic [22:0]                   r_inc;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [CORD_W-1:0]      r_x;
    logic signed [CORD_W-1:0]      r_y;
    logic signed [ANG_W-1:0]       r_z;
    logic signed [RAD_W-1:0]       r_rad;
    logic signed [RES_W-1:0]       r_s;
    logic signed [SAMPLE_BITS-1:0] r_res_l;
    logic signed [SAMPLE_BITS-1:0] r_res_r;

    logic [SINE_ADDR_W-1:0]        rom_addr;
    logic [16:0]                   d_eff;
    logic [16:0]                   d_comp;
    logic signed [SAMPLE_BITS-1:0] cur;
    logic signed [LFO_W-1:0]       lfo1_c;
    logic signed [17:0]            sin_sum;
    logic [31:0]                   tri_dn;
    logic [31:0]                   tri_up;
    logic [31:0]                   sq_dn;
    logic [31:0]                   sq_up;
    logic [37:0]                   sq_dn_m;
    logic [37:0]                   sq_up_m;
    logic signed [MUL_W-1:0]       mul_a;
    logic signed [MUL_W-1:0]       mul_b;
    logic signed [2*MUL_W-1:0]     prod_full;
    logic signed [CORD_W-1:0]      dx;
    logic signed [CORD_W-1:0]      dy;
    logic signed [ANG_W-1:0]       ang;
    logic signed [PROD_W-1:0]      rnd_rad;
    logic signed [PROD_W-1:0]      rnd_scl;
    logic signed [PROD_W-1:0]      scl_sh;
    logic signed [PROD_W-1:0]      rnd_out;
    logic signed [SAMPLE_BITS-1:0] sat_out;
    logic signed [CORD_W-1:0]      shv_y;

    assign rom_addr = (i_cmd.op == OP_SIN1) ? r_ph1[31 -: SINE_ADDR_W]
                                             : r_ph2[31 -: SINE_ADDR_W];
    assign d_eff    = (r_depth_one > 16'd32768) ? 17'd32768 : {1'b0, r_depth_one};
    assign d_comp   = 17'd32768 - d_eff;
    assign cur      = i_cmd.ch ? r_right : r_left;
    assign sin_sum  = {r_sin[SINE_W-1], r_sin} + 18'sd32768;
    assign tri_dn   = r_ph1 - 32'h4000_0000;
    assign tri_up   = r_ph1 - 32'hC000_0000;
    assign sq_dn    = r_ph1 - SQ_T48;
    assign sq_up    = r_ph1 - SQ_T98;
    assign sq_dn_m  = {6'd0, sq_dn} * 38'd50;
    assign sq_up_m  = {6'd0, sq_up} * 38'd50;

    always_comb begin
        case (r_wave_select)
            WAVE_TRI: begin
                if (r_ph1 < 32'h4000_0000) begin
                    lfo1_c = $signed(17'd16384 + {1'b0, r_ph1[31:16]});
                end else if (r_ph1 < 32'hC000_0000) begin
                    lfo1_c = $signed(17'd32768 - {1'b0, tri_dn[31:16]});
                end else begin
                    lfo1_c = $signed({1'b0, tri_up[31:16]});
                end
            end
            WAVE_SQUARE: begin
                if (r_ph1 < SQ_T48) begin
                    lfo1_c = $signed(17'd32768);
                end else if (r_ph1 < SQ_T50) begin
                    lfo1_c = $signed(17'd32768 - sq_dn_m[33:17]);
                end else if (r_ph1 < SQ_T98) begin
                    lfo1_c = '0;
                end else begin
                    lfo1_c = $signed(sq_up_m[33:17]);
                end
            end
            WAVE_RING: lfo1_c = r_sin;
            default:   lfo1_c = sin_sum[17:1];
        endcase
    end

    always_comb begin
        case (i_cmd.op)
            OP_GMUL: begin
                mul_a = {{(MUL_W-17){1'b0}}, d_eff};
                mul_b = {{(MUL_W-LFO_W){r_lfo1[LFO_W-1]}}, r_lfo1};
            end
            OP_GAIN: begin
                mul_a = {{(MUL_W-22){1'b0}}, r_mod_depth_step};
                mul_b = {{(MUL_W-LFO_W){1'b0}}, r_lfo2};
            end
            OP_INC: begin
                mul_a = {{(MUL_W-24){1'b0}}, r_rate_one_step};
                mul_b = {{(MUL_W-3){1'b0}}, r_rate_multiplier};
            end
            OP_CH: begin
                mul_a = {{(MUL_W-SAMPLE_BITS){cur[SAMPLE_BITS-1]}}, cur};
                mul_b = {{(MUL_W-16){1'b0}}, r_shaper_gain};
            end
            OP_RAD: begin
                mul_a = {{(MUL_W-ANG_W){r_z[ANG_W-1]}}, r_z};
                mul_b = {{(MUL_W-31){1'b0}}, TWO_PI_Q28};
            end
            OP_SCL: begin
                mul_a = {{(MUL_W-RAD_W){r_rad[RAD_W-1]}}, r_rad};
                mul_b = MUL_W'(SHAPER_SCALE_Q15);
            end
            OP_OUTM: begin
                mul_a = {{(MUL_W-RES_W){r_s[RES_W-1]}}, r_s};
                mul_b = {{(MUL_W-32){r_gain[31]}}, r_gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    assign dx      = r_y >>> i_cmd.step;
    assign dy      = r_x >>> i_cmd.step;
    assign ang     = {{(ANG_W-ANG_TAB_W){1'b0}}, CORDIC_ANGLE[i_cmd.step]};
    assign rnd_rad = (r_prod + RAD_RND) >>> RAD_SHIFT;
    assign rnd_scl = (r_prod + SCL_RND) >>> 15;
    assign scl_sh  = rnd_scl <<< 11;
    assign rnd_out = (r_prod + OUT_RND) >>> 30;
    assign sat_out = (rnd_out > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                     (rnd_out < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] :
                                          rnd_out[SAMPLE_BITS-1:0];
    assign shv_y   = r_prod[PROD_W-1] ? r_prod[CORD_W-1:0] :
                     (r_prod > ONE_V) ? ONE_V[CORD_W-1:0] : r_prod[CORD_W-1:0];

    assign o_status.shaper_on = r_shaper_enable;
    assign o_status.v_neg     = r_prod[PROD_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shaper_enable   <= 1'b0;
            r_shaper_gain     <= 16'd3277;
            r_wave_select     <= WAVE_SINE;
            r_rate_multiplier <= 3'd1;
            r_depth_one       <= 16'd0;
            r_rate_one_step   <= 24'd895;
            r_mod_depth_step  <= 22'd0;
            r_rate_two_step   <= 17'd895;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SHAPER_ENABLE:   r_shaper_enable   <= i_cfg_data[0];
                REG_SHAPER_GAIN:     r_shaper_gain     <= i_cfg_data[15:0];
                REG_WAVE_SELECT:     r_wave_select     <= t_wave'(i_cfg_data[1:0]);
                REG_RATE_MULTIPLIER: r_rate_multiplier <= i_cfg_data[2:0];
                REG_DEPTH_ONE:       r_depth_one       <= i_cfg_data[15:0];
                REG_RATE_ONE_STEP:   r_rate_one_step   <= i_cfg_data[23:0];
                REG_MOD_DEPTH_STEP:  r_mod_depth_step  <= i_cfg_data[21:0];
                REG_RATE_TWO_STEP:   r_rate_two_step   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1 <= '0;
            r_ph2 <= '0;
        end else if (i_cmd.op == OP_PHASE) begin
            r_ph1 <= r_ph1 + {9'd0, r_inc} + r_prod[31:0];
            r_ph2 <= r_ph2 + {15'd0, r_rate_two_step};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full[PROD_W-1:0];
        r_sin  <= SINE_TAB[rom_addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_left  <= i_left_in;
                r_right <= i_right_in;
            end
            OP_LFO1: r_lfo1 <= lfo1_c;
            OP_GMUL: r_lfo2 <= sin_sum[17:1];
            OP_GAIN: r_gain <= $signed({d_comp, 15'd0}) + r_prod[31:0];
            OP_INC:  r_inc  <= r_prod[37:15];
            OP_CH:   r_s    <= {{(RES_W-SAMPLE_BITS){cur[SAMPLE_BITS-1]}}, cur};
            OP_SHV: begin
                r_x <= ONE_V[CORD_W-1:0];
                r_y <= shv_y;
                r_z <= '0;
            end
            OP_CORD: begin
                if (!r_y[CORD_W-1]) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + ang;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - ang;
                end
            end
            OP_RADR: r_rad <= rnd_rad[RAD_W-1:0];
            OP_SCLR: begin
                if (i_cmd.neg) begin
                    r_x <= ONE_V[CORD_W-1:0];
                    r_y <= scl_sh[CORD_W-1:0];
                    r_z <= '0;
                end else begin
                    r_s <= rnd_scl[RES_W-1:0];
                end
            end
            OP_OUTR: begin
                if (i_cmd.ch) begin
                    r_res_r <= sat_out;
                end else begin
                    r_res_l <= sat_out;
                end
            end
            OP_EMIT: begin
                o_left_out  <= r_res_l;
                o_right_out <= r_res_r;
            end
            default: ;
        endcase
    end

endmodule

[rtl/tremolo_lfo_softclip.sv]
// Each accepted input item yields one output item; with the clipper on, each channel
// runs the CORDIC unit once, or twice for a negative sample (two atans).
// A new item is taken only once the last one has been emitted. The single shared
// multiplier and the iterative 30-step CORDIC unit are used by both channels in turn.
// Reset: synchronous, active low; clears the LFO phases, the control state and the
// configuration registers to their defaults. The sine table is a constant ROM.
module tremolo_lfo_softclip
    import tls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tls_in_if.sink               i_in,
    tls_out_if.source            o_out
);

    t_cmd    cmd;
    t_status status;

    tls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tls_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_left_in   (i_in.left_in),
        .i_right_in  (i_in.right_in),
        .o_status    (status),
        .o_left_out  (o_out.left_out),
        .o_right_out (o_out.right_out)
    );

`ifndef ASSERT_OFF
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an item was in progress");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_EMIT) |=> o_out.valid)
        else $error("result load did not raise output valid");

    a_cordic_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_CORD) |-> (cmd.step < STEP_W'(CORDIC_STEPS)))
        else $error("CORDIC step index out of range");
`endif

endmodule
